@@ rtl/day_indexed_permutation_order_defines.svh @@
// ----------------------------------------------------------------------------
// day_indexed_permutation_order_defines
// assertion macros shared by the day indexed permutation order block
// ----------------------------------------------------------------------------
`ifndef DAY_INDEXED_PERMUTATION_ORDER_DEFINES_SVH
`define DAY_INDEXED_PERMUTATION_ORDER_DEFINES_SVH

`ifndef ASSERT_OFF

// antecedent implies consequent in the same cycle
`define DIPO_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define DIPO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define DIPO_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define DIPO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ rtl/dipo_pkg.sv @@
// ----------------------------------------------------------------------------
// dipo_pkg
// types, constants and helper functions of the day indexed permutation order
// ----------------------------------------------------------------------------
package dipo_pkg;

    localparam int unsigned PERM_LEN  = 11;
    localparam int unsigned MAX_SLOTS = 11;
    localparam int unsigned SLOT_W    = 4;
    localparam int unsigned DAY_W     = 16;
    localparam int unsigned TS_W      = 32;
    localparam int unsigned TW        = 26;

    localparam logic [TS_W-1:0]  BASE_TIME_RESET = 32'd1462060800;
    localparam logic [DAY_W-1:0] DAY_MAX         = 16'd49710;

    // seconds per day split into a power of two and an odd factor
    localparam int unsigned SEC_PER_DAY = 60 * 60 * 24;
    localparam int unsigned SEC_SHIFT   = 7;
    localparam int unsigned SEC_ODD     = SEC_PER_DAY >> SEC_SHIFT;
    localparam int unsigned QW          = TS_W - SEC_SHIFT;
    localparam int unsigned DAY_SHIFT   = QW + 10;
    localparam int unsigned MW          = 26;
    localparam int unsigned PW          = QW + MW;
    localparam logic [MW-1:0] DAY_MULT  =
        MW'(((64'd1 << DAY_SHIFT) + 64'(SEC_ODD) - 64'd1) / 64'(SEC_ODD));

    localparam logic [TW-1:0] FACT_TAB [MAX_SLOTS+1] = '{
        26'd1, 26'd1, 26'd2, 26'd6, 26'd24, 26'd120, 26'd720, 26'd5040,
        26'd40320, 26'd362880, 26'd3628800, 26'd39916800
    };

    // rank = day mod PERM_LEN! through a reciprocal multiply
    localparam logic [TW-1:0] FACT_LEN  = FACT_TAB[PERM_LEN];
    localparam int unsigned   MOD_SHIFT = 32;
    localparam logic [31:0]   MOD_MULT  =
        32'(((64'd1 << MOD_SHIFT) + 64'(FACT_LEN) - 64'd1) / 64'(FACT_LEN));

    typedef logic [MAX_SLOTS-1:0][SLOT_W-1:0] dipo_slots_t;
    typedef logic [MAX_SLOTS-1:0][TW-1:0]     dipo_thr_t;

    typedef struct packed {
        logic [DAY_W-1:0] day;
        logic [DAY_W-1:0] rank;
        dipo_slots_t      pool;
        dipo_slots_t      slots;
    } dipo_item_t;

    // digit thresholds j * k! for one position of the factorial number system
    function automatic dipo_thr_t cell_thr(int unsigned k);
        dipo_thr_t thr;
        for (int unsigned j = 0; j < MAX_SLOTS; j++)
        begin
            thr[j] = TW'(j * FACT_TAB[k]);
        end
        return thr;
    endfunction

endpackage

@@ rtl/dipo_front.sv @@
// ----------------------------------------------------------------------------
// dipo_front
// day number by reciprocal multiply, then rank reduction modulo PERM_LEN!
// ----------------------------------------------------------------------------
module dipo_front
    import dipo_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [TS_W-1:0]  start_epoch,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [TS_W-1:0]  timestamp,
    output logic             item_valid,
    input  logic             item_stall,
    output dipo_item_t       item
);

    logic [3:0]             valid_reg;
    logic [4:0]             hold;
    logic [QW-1:0]          diff_reg;
    logic [DAY_W-1:0]       day2_reg;
    logic [DAY_W-1:0]       day3_reg;
    logic [DAY_W-1:0]       quot_reg;
    logic [DAY_W-1:0]       day4_reg;
    logic [DAY_W-1:0]       rank_reg;
    logic [TS_W-1:0]        diff_next;
    logic [PW-1:0]          day_prod;
    logic [DAY_W+31:0]      mod_prod;
    logic [DAY_W+TW-1:0]    sub_prod;

    always_comb
    begin
        hold[4] = item_stall;
        for (int k = 3; k >= 0; k--)
        begin
            hold[k] = valid_reg[k] & hold[k+1];
        end
    end

    assign in_stall  = hold[0];
    assign diff_next = timestamp - start_epoch;
    assign day_prod  = PW'(diff_reg) * PW'(DAY_MULT);
    assign mod_prod  = (DAY_W+32)'(day2_reg) * (DAY_W+32)'(MOD_MULT);
    assign sub_prod  = (DAY_W+TW)'(quot_reg) * (DAY_W+TW)'(FACT_LEN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (!hold[0]) valid_reg[0] <= in_valid;
            for (int k = 1; k < 4; k++)
            begin
                if (!hold[k]) valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!hold[0] && in_valid)
        begin
            diff_reg <= diff_next[TS_W-1:SEC_SHIFT];
        end
        if (!hold[1] && valid_reg[0])
        begin
            day2_reg <= day_prod[DAY_SHIFT +: DAY_W];
        end
        if (!hold[2] && valid_reg[1])
        begin
            day3_reg <= day2_reg;
            quot_reg <= mod_prod[MOD_SHIFT +: DAY_W];
        end
        if (!hold[3] && valid_reg[2])
        begin
            day4_reg <= day3_reg;
            rank_reg <= day3_reg - sub_prod[DAY_W-1:0];
        end
    end

    always_comb
    begin
        item.day   = day4_reg;
        item.rank  = rank_reg;
        item.slots = '0;
        for (int k = 0; k < MAX_SLOTS; k++)
        begin
            item.pool[k] = SLOT_W'(k);
        end
    end

    assign item_valid = valid_reg[3];

endmodule

@@ rtl/dipo_cell.sv @@
// ----------------------------------------------------------------------------
// dipo_cell
// one factorial digit: picks an entry from the pool and passes the rest on
// ----------------------------------------------------------------------------
module dipo_cell
    import dipo_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  dipo_thr_t           thr,
    input  logic [SLOT_W-1:0]   last,
    input  logic                up_valid,
    output logic                up_stall,
    input  dipo_item_t          up_item,
    output logic                dn_valid,
    input  logic                dn_stall,
    output dipo_item_t          dn_item
);

    logic                valid_reg;
    dipo_item_t          item_reg;
    dipo_item_t          item_next;
    logic [SLOT_W-1:0]   count;
    logic [SLOT_W-1:0]   pick;
    logic                hold;

    assign hold     = valid_reg & dn_stall;
    assign up_stall = hold;

    always_comb
    begin
        count = '0;
        for (int j = 1; j < MAX_SLOTS; j++)
        begin
            if ({(TW-DAY_W)'(0), up_item.rank} >= thr[j])
            begin
                count = count + SLOT_W'(1);
            end
        end
        pick = (count > last) ? last : count;
    end

    always_comb
    begin
        item_next.day  = up_item.day;
        item_next.rank = up_item.rank - thr[pick][DAY_W-1:0];
        for (int k = 0; k < MAX_SLOTS - 1; k++)
        begin
            item_next.pool[k]  = (SLOT_W'(k) < pick) ? up_item.pool[k] : up_item.pool[k+1];
            item_next.slots[k] = up_item.slots[k+1];
        end
        item_next.pool[MAX_SLOTS-1]  = '0;
        item_next.slots[MAX_SLOTS-1] = up_item.pool[pick];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!hold)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!hold && up_valid)
        begin
            item_reg <= item_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_item  = item_reg;

endmodule

@@ rtl/day_indexed_permutation_order.sv @@
// throughput: one transaction per cycle when not stalled; front end of subtract, day and rank
// multiplies, then one cell per permutation position, each a register stage
// stalls propagate per stage, so bubbles are absorbed while the output waits
// reset clears all valid flags and loads the day zero epoch with 1462060800
// ----------------------------------------------------------------------------
// day_indexed_permutation_order
// maps a timestamp to its day number and the permutation of that rank
// ----------------------------------------------------------------------------
`include "day_indexed_permutation_order_defines.svh"

module day_indexed_permutation_order
    import dipo_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [TS_W-1:0]    cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [TS_W-1:0]    timestamp,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [DAY_W-1:0]   day_number,
    output logic [SLOT_W-1:0]  slot_0,
    output logic [SLOT_W-1:0]  slot_1,
    output logic [SLOT_W-1:0]  slot_2,
    output logic [SLOT_W-1:0]  slot_3,
    output logic [SLOT_W-1:0]  slot_4,
    output logic [SLOT_W-1:0]  slot_5,
    output logic [SLOT_W-1:0]  slot_6,
    output logic [SLOT_W-1:0]  slot_7,
    output logic [SLOT_W-1:0]  slot_8,
    output logic [SLOT_W-1:0]  slot_9,
    output logic [SLOT_W-1:0]  slot_10
);

    logic [TS_W-1:0]  start_epoch_reg;
    logic             chain_valid [PERM_LEN+1];
    logic             chain_stall [PERM_LEN+1];
    dipo_item_t       chain_item  [PERM_LEN+1];
    dipo_item_t       last_item;
    dipo_slots_t      slot_arr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_epoch_reg <= BASE_TIME_RESET;
        end
        else if (cfg_we)
        begin
            start_epoch_reg <= cfg_data;
        end
    end

    dipo_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start_epoch (start_epoch_reg),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .timestamp   (timestamp),
        .item_valid  (chain_valid[0]),
        .item_stall  (chain_stall[0]),
        .item        (chain_item[0])
    );

    for (genvar i = 0; i < PERM_LEN; i++)
    begin : g_cell
        dipo_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .thr      (cell_thr(PERM_LEN - 1 - i)),
            .last     (SLOT_W'(PERM_LEN - 1 - i)),
            .up_valid (chain_valid[i]),
            .up_stall (chain_stall[i]),
            .up_item  (chain_item[i]),
            .dn_valid (chain_valid[i+1]),
            .dn_stall (chain_stall[i+1]),
            .dn_item  (chain_item[i+1])
        );
    end

    assign chain_stall[PERM_LEN] = out_stall;
    assign last_item             = chain_item[PERM_LEN];
    assign out_valid             = chain_valid[PERM_LEN];
    assign day_number            = last_item.day;

    // picks land at the top of the slot queue, first pick lowest
    always_comb
    begin
        for (int j = 0; j < MAX_SLOTS; j++)
        begin
            if (j < PERM_LEN)
            begin
                slot_arr[j] = last_item.slots[MAX_SLOTS - PERM_LEN + j];
            end
            else
            begin
                slot_arr[j] = '0;
            end
        end
    end

    assign slot_0  = slot_arr[0];
    assign slot_1  = slot_arr[1];
    assign slot_2  = slot_arr[2];
    assign slot_3  = slot_arr[3];
    assign slot_4  = slot_arr[4];
    assign slot_5  = slot_arr[5];
    assign slot_6  = slot_arr[6];
    assign slot_7  = slot_arr[7];
    assign slot_8  = slot_arr[8];
    assign slot_9  = slot_arr[9];
    assign slot_10 = slot_arr[10];

    `DIPO_ASSERT_IMPLY(a_day_range, clk, rst_n, out_valid, day_number <= DAY_MAX, "day number out of range")
    `DIPO_ASSERT_IMPLY(a_slot_range, clk, rst_n, out_valid, slot_0 < SLOT_W'(PERM_LEN), "first slot out of range")
    `DIPO_ASSERT_IMPLY(a_slot_distinct, clk, rst_n, out_valid, slot_0 != slot_1, "repeated entry in order")
    `DIPO_ASSERT_NEXT(a_cfg_load, clk, rst_n, cfg_we, start_epoch_reg == $past(cfg_data), "epoch not loaded")

endmodule
